FILE: sv/odv_pkg.sv
// ----------------------------------------------------------------------------
// odv_pkg
// Shared constants, types and helper functions of the one-bit drum voices.
// ----------------------------------------------------------------------------
package odv_pkg;

    localparam int CHANNELS    = 8;
    localparam int NOISE_DEPTH = 16384;
    localparam int PATCHES     = 12;

    localparam int CH_W  = 3;
    localparam int PT_W  = 4;
    localparam int CFG_W = 23;
    localparam int IDX_W = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SPMS       = 2'd1;
    localparam logic [IDX_W-1:0] CFG_POLY       = 2'd2;
    localparam logic [IDX_W-1:0] CFG_GAIN       = 2'd3;

    localparam logic [22:0] RST_PHASE_STEP = 23'd357914;
    localparam logic [7:0]  RST_SPMS       = 8'd48;
    localparam logic        RST_POLY       = 1'b1;
    localparam logic [8:0]  RST_GAIN       = 9'd256;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_NOTE  = 2'd1;
    localparam logic [1:0] OP_PATCH = 2'd2;

    // patch fields
    localparam logic [2:0] PF_DUR  = 3'd0;
    localparam logic [2:0] PF_MIN  = 3'd1;
    localparam logic [2:0] PF_MAX  = 3'd2;
    localparam logic [2:0] PF_SEED = 3'd3;
    localparam logic [2:0] PF_TYPE = 3'd4;
    localparam logic [2:0] PF_VOL  = 3'd5;

    // noise generator
    localparam logic [30:0] LEH_MOD  = 31'h7FFF_FFFF;
    localparam logic [15:0] LEH_MUL  = 16'd48271;
    localparam logic [30:0] LEH_KEEP = 31'd2147483392;
    localparam logic [22:0] LEH_DIV  = 23'd8388607;

    // reciprocals: floor(x/100) = (x*M100)>>28, floor(y/3) = (y*M3)>>21
    localparam logic [21:0] M100 = 22'd2684355;
    localparam logic [19:0] M3   = 20'd699051;

    localparam int DIV_STEPS = 13;

    typedef struct packed {
        logic            fill_mul;
        logic            fill_red;
        logic            capture;
        logic            patch_wr;
        logic            tick_start;
        logic            ch_load;
        logic            step_dec;
        logic            reload;
        logic            div_iter;
        logic            div_end;
        logic            ch_store;
        logic            mix1;
        logic            mix2;
        logic            mix3;
        logic            note2;
        logic            note3;
        logic            note4;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic n_zero;
        logic delay_gt1;
        logic need_div;
        logic vel_zero;
        logic out_free;
    } t_sts;

    function automatic logic [PT_W-1:0] note_mod12(input logic [6:0] n);
        logic [13:0] q;
        logic [10:0] m;
        q = 14'(n) * 14'd43;
        m = 11'(q[13:9]) * 11'd12;
        return PT_W'(11'(n) - m);
    endfunction

    function automatic logic [CH_W-1:0] patch_chan(input logic [PT_W-1:0] p);
        logic [CH_W-1:0] c;
        case (p)
            4'd0:    c = 3'd0;
            4'd2:    c = 3'd1;
            4'd4:    c = 3'd2;
            4'd5:    c = 3'd3;
            4'd7:    c = 3'd4;
            4'd9:    c = 3'd5;
            4'd11:   c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/odv_ctrl.sv
// ----------------------------------------------------------------------------
// odv_ctrl
// Sequencer: ROM fill, per-channel inner steps, mix, note on and patch writes.
// ----------------------------------------------------------------------------
module odv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_opcode,
    input  odv_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output odv_pkg::t_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_FILL_MUL = 15'b000000000000001,
        S_FILL_RED = 15'b000000000000010,
        S_IDLE     = 15'b000000000000100,
        S_CH_LOAD  = 15'b000000000001000,
        S_STEP     = 15'b000000000010000,
        S_RELOAD   = 15'b000000000100000,
        S_DIV      = 15'b000000001000000,
        S_DIV_END  = 15'b000000010000000,
        S_CH_STORE = 15'b000000100000000,
        S_MIX1     = 15'b000001000000000,
        S_MIX2     = 15'b000010000000000,
        S_MIX3     = 15'b000100000000000,
        S_NOTE2    = 15'b001000000000000,
        S_NOTE3    = 15'b010000000000000,
        S_NOTE4    = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic [odv_pkg::CH_W-1:0] r_ch, n_ch;
    logic [3:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL_MUL;
            r_ch    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            S_FILL_MUL: begin
                o_cmd.fill_mul = 1'b1;
                n_state = S_FILL_RED;
            end
            S_FILL_RED: begin
                o_cmd.fill_red = 1'b1;
                n_state = i_sts.fill_done ? S_IDLE : S_FILL_MUL;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_opcode)
                        odv_pkg::OP_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_ch    = '0;
                            n_state = S_CH_LOAD;
                        end
                        odv_pkg::OP_NOTE:  n_state = S_NOTE2;
                        odv_pkg::OP_PATCH: o_cmd.patch_wr = 1'b1;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_CH_LOAD: begin
                o_cmd.ch_load = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (i_sts.n_zero) begin
                    n_state = S_CH_STORE;
                end else if (i_sts.delay_gt1) begin
                    o_cmd.step_dec = 1'b1;
                end else begin
                    n_state = S_RELOAD;
                end
            end
            S_RELOAD: begin
                o_cmd.reload = 1'b1;
                n_cnt   = '0;
                n_state = i_sts.need_div ? S_DIV : S_STEP;
            end
            S_DIV: begin
                o_cmd.div_iter = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(odv_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state = S_STEP;
            end
            S_CH_STORE: begin
                o_cmd.ch_store = 1'b1;
                if (r_ch == odv_pkg::CH_W'(odv_pkg::CHANNELS - 1)) begin
                    n_state = S_MIX1;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_CH_LOAD;
                end
            end
            S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state = S_MIX3;
            end
            S_MIX3: begin
                if (i_sts.out_free) begin
                    o_cmd.mix3 = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NOTE2: begin
                if (i_sts.vel_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.note2 = 1'b1;
                    n_state = S_NOTE3;
                end
            end
            S_NOTE3: begin
                o_cmd.note3 = 1'b1;
                n_state = S_NOTE4;
            end
            S_NOTE4: begin
                o_cmd.note4 = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/odv_dp.sv
// ----------------------------------------------------------------------------
// odv_dp
// Datapath: noise ROM, patch table, channel state, delay folding divider, mix.
// ----------------------------------------------------------------------------
module odv_dp #(
    parameter int NOISE_DEPTH = odv_pkg::NOISE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  odv_pkg::t_cmd             i_cmd,
    output odv_pkg::t_sts             o_sts,
    input  logic                      i_cfg_we,
    input  logic [odv_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [odv_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [30:0]               i_in_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [23:0]               o_out_data
);

    localparam int AW = $clog2(NOISE_DEPTH);
    localparam int CN = odv_pkg::CHANNELS;
    localparam int PN = odv_pkg::PATCHES;

    // configuration
    logic [22:0] r_phase_step;
    logic [7:0]  r_spms;
    logic        r_poly;
    logic [8:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= odv_pkg::RST_PHASE_STEP;
            r_spms       <= odv_pkg::RST_SPMS;
            r_poly       <= odv_pkg::RST_POLY;
            r_gain       <= odv_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                odv_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                odv_pkg::CFG_SPMS:       r_spms       <= i_cfg_data[7:0];
                odv_pkg::CFG_POLY:       r_poly       <= i_cfg_data[0];
                odv_pkg::CFG_GAIN:       r_gain       <= i_cfg_data[8:0];
                default:                 r_gain       <= r_gain;
            endcase
        end
    end

    // input fields, lowest first: note, velocity, patch_field, patch_value
    logic [6:0]  in_note, in_vel;
    logic [2:0]  in_field;
    logic [13:0] in_val;
    assign in_note  = i_in_data[6:0];
    assign in_vel   = i_in_data[13:7];
    assign in_field = i_in_data[16:14];
    assign in_val   = i_in_data[30:17];

    logic [6:0] r_note, r_vel;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_note <= in_note;
            r_vel  <= in_vel;
        end
    end

    // ROM fill generator
    logic [30:0] r_x;
    logic [46:0] r_xprod;
    logic [AW:0] r_fill_idx;
    logic [31:0] red_s;
    logic [30:0] red_p, red_r;
    logic [23:0] red_t;
    logic [7:0]  red_byte;
    logic        red_keep;

    always_comb begin
        red_s    = {1'b0, r_xprod[30:0]} + 32'(r_xprod[46:31]);
        red_p    = (red_s >= 32'(odv_pkg::LEH_MOD)) ? 31'(red_s - 32'(odv_pkg::LEH_MOD))
                                                     : red_s[30:0];
        red_r    = red_p - 31'd1;
        red_keep = red_r < odv_pkg::LEH_KEEP;
        red_t    = 24'(red_r[22:0]) + 24'(red_r[30:23]);
        red_byte = red_r[30:23] + 8'(red_t >= 24'(odv_pkg::LEH_DIV));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= 31'd1;
            r_fill_idx <= '0;
        end else if (i_cmd.fill_red) begin
            r_x <= red_p;
            if (red_keep) begin
                r_fill_idx <= r_fill_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_mul) begin
            r_xprod <= 47'(r_x) * 47'(odv_pkg::LEH_MUL);
        end
    end

    // noise memory
    logic [7:0] mem_rom [NOISE_DEPTH];
    logic [7:0] r_rom_q;
    logic [13:0] w_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_red && red_keep) begin
            mem_rom[r_fill_idx[AW-1:0]] <= red_byte;
        end
        r_rom_q <= mem_rom[AW'(w_ptr)];
    end

    // patch table
    logic [7:0]  pt_dur [PN];
    logic [7:0]  pt_min [PN];
    logic [7:0]  pt_max [PN];
    logic [13:0] pt_seed [PN];
    logic        pt_type [PN];
    logic [7:0]  pt_vol [PN];
    logic [odv_pkg::PT_W-1:0] wr_p;
    assign wr_p = odv_pkg::note_mod12(in_note);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PN; i++) begin
                pt_dur[i]  <= '0;
                pt_min[i]  <= '0;
                pt_max[i]  <= '0;
                pt_seed[i] <= '0;
                pt_type[i] <= 1'b0;
                pt_vol[i]  <= '0;
            end
        end else if (i_cmd.patch_wr) begin
            case (in_field)
                odv_pkg::PF_DUR:  pt_dur[wr_p]  <= (in_val > 14'd250) ? 8'd250 : in_val[7:0];
                odv_pkg::PF_MIN:  pt_min[wr_p]  <= (in_val > 14'd255) ? 8'd255 : in_val[7:0];
                odv_pkg::PF_MAX:  pt_max[wr_p]  <= (in_val > 14'd255) ? 8'd255 : in_val[7:0];
                odv_pkg::PF_SEED: pt_seed[wr_p] <= in_val;
                odv_pkg::PF_TYPE: pt_type[wr_p] <= (in_val != 14'd0);
                odv_pkg::PF_VOL:  pt_vol[wr_p]  <= (in_val > 14'd255) ? 8'd255 : in_val[7:0];
                default:          pt_type[wr_p] <= pt_type[wr_p];
            endcase
        end
    end

    // channel state
    logic [15:0] ch_dur [CN];
    logic [15:0] ch_phase [CN];
    logic [13:0] ch_delay [CN];
    logic [13:0] ch_ptr [CN];
    logic [11:0] ch_lo [CN];
    logic [11:0] ch_hi [CN];
    logic [14:0] ch_vol [CN];
    logic        ch_kind [CN];
    logic        ch_bit [CN];

    // working copy of one channel
    logic [15:0] w_dur, w_phase;
    logic [13:0] w_delay;
    logic [11:0] w_lo, w_hi;
    logic        w_kind, w_bit;
    logic [7:0]  w_n;

    logic [23:0] acc;
    assign acc = 24'(ch_phase[i_cmd.ch]) + 24'(r_phase_step);

    // reload arithmetic
    logic [10:0] rl_d;
    logic [12:0] rl_fold;
    logic [11:0] rl_clamp;
    assign rl_d     = {r_rom_q, 3'b000};
    assign rl_fold  = ((12'(rl_d) < w_lo) && (w_lo != 12'd0)) ? 13'(rl_d) + 13'(w_lo)
                                                               : 13'(rl_d);
    assign rl_clamp = (12'(rl_d) < w_lo) ? w_lo : ((12'(rl_d) > w_hi) ? w_hi : 12'(rl_d));

    // remainder divider
    logic [12:0] r_dvd;
    logic [11:0] r_rem;
    logic [12:0] dv_t;
    assign dv_t = {r_rem, r_dvd[12]};

    logic need_div;
    assign need_div = w_kind && (w_hi != 12'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ch_load) begin
            w_lo    <= ch_lo[i_cmd.ch];
            w_hi    <= ch_hi[i_cmd.ch];
            w_kind  <= ch_kind[i_cmd.ch];
            w_delay <= ch_delay[i_cmd.ch];
            w_ptr   <= ch_ptr[i_cmd.ch];
            if (ch_dur[i_cmd.ch] != 16'd0) begin
                w_dur   <= ch_dur[i_cmd.ch] - 16'd1;
                w_phase <= acc[15:0];
                w_n     <= acc[23:16];
                w_bit   <= ch_bit[i_cmd.ch];
            end else begin
                w_dur   <= 16'd0;
                w_phase <= ch_phase[i_cmd.ch];
                w_n     <= 8'd0;
                w_bit   <= 1'b0;
            end
        end else if (i_cmd.step_dec) begin
            w_delay <= w_delay - 14'd1;
            w_n     <= w_n - 8'd1;
        end else if (i_cmd.reload) begin
            if (need_div) begin
                r_dvd <= rl_fold;
                r_rem <= 12'd0;
            end else begin
                w_delay <= w_kind ? 14'(rl_fold) : 14'(rl_clamp);
                w_ptr   <= w_ptr + 14'd1;
                w_bit   <= ~w_bit;
                w_n     <= w_n - 8'd1;
            end
        end else if (i_cmd.div_iter) begin
            r_dvd <= {r_dvd[11:0], 1'b0};
            r_rem <= (dv_t >= 13'(w_hi)) ? 12'(dv_t - 13'(w_hi)) : dv_t[11:0];
        end else if (i_cmd.div_end) begin
            w_delay <= 14'(r_rem);
            w_ptr   <= w_ptr + 14'd1;
            w_bit   <= ~w_bit;
            w_n     <= w_n - 8'd1;
        end
    end

    // note on
    logic [odv_pkg::PT_W-1:0] nt_p;
    logic [odv_pkg::CH_W-1:0] nt_c, r_nc;
    logic [7:0]  nt_a, nt_b;
    logic [14:0] r_vp;
    logic [42:0] r_vprod;
    assign nt_p = odv_pkg::note_mod12(r_note);
    assign nt_c = r_poly ? odv_pkg::patch_chan(nt_p) : '0;
    assign nt_a = (pt_min[nt_p] > pt_max[nt_p]) ? pt_max[nt_p] : pt_min[nt_p];
    assign nt_b = (pt_min[nt_p] > pt_max[nt_p]) ? pt_min[nt_p] : pt_max[nt_p];

    always_ff @(posedge i_clk) begin
        if (i_cmd.note2) begin
            r_nc <= nt_c;
            r_vp <= 15'(pt_vol[nt_p]) * 15'(r_vel);
        end
        if (i_cmd.note3) begin
            r_vprod <= 43'({r_vp, 6'b000000}) * 43'(odv_pkg::M100);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CN; i++) begin
                ch_dur[i]   <= '0;
                ch_phase[i] <= '0;
                ch_delay[i] <= '0;
                ch_ptr[i]   <= '0;
                ch_lo[i]    <= '0;
                ch_hi[i]    <= '0;
                ch_vol[i]   <= '0;
                ch_kind[i]  <= 1'b0;
                ch_bit[i]   <= 1'b0;
            end
        end else if (i_cmd.ch_store) begin
            ch_dur[i_cmd.ch]   <= w_dur;
            ch_phase[i_cmd.ch] <= w_phase;
            ch_delay[i_cmd.ch] <= w_delay;
            ch_ptr[i_cmd.ch]   <= w_ptr;
            ch_bit[i_cmd.ch]   <= w_bit;
        end else if (i_cmd.note2) begin
            ch_dur[nt_c]   <= 16'(pt_dur[nt_p]) * 16'(r_spms);
            ch_phase[nt_c] <= '0;
            ch_delay[nt_c] <= '0;
            ch_ptr[nt_c]   <= pt_seed[nt_p];
            ch_lo[nt_c]    <= {1'b0, nt_a, 3'b000};
            ch_hi[nt_c]    <= {1'b0, nt_b, 3'b000};
            ch_kind[nt_c]  <= pt_type[nt_p];
            ch_bit[nt_c]   <= 1'b0;
        end else if (i_cmd.note4) begin
            ch_vol[r_nc] <= r_vprod[42:28];
        end
    end

    // mix
    logic [17:0] r_sum;
    logic [26:0] r_mprod;
    logic [38:0] r_qprod;
    logic [8:0]  gain_sat;
    logic [17:0] lvl;
    logic [7:0]  bits;
    assign gain_sat = (r_gain > 9'd256) ? 9'd256 : r_gain;
    assign lvl      = r_qprod[38:21];

    always_comb begin
        for (int i = 0; i < CN; i++) begin
            bits[i] = ch_bit[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_sum <= '0;
        end else if (i_cmd.ch_store && w_bit) begin
            r_sum <= r_sum + 18'(ch_vol[i_cmd.ch]);
        end
        if (i_cmd.mix1) begin
            r_mprod <= 27'(r_sum) * 27'(gain_sat);
        end
        if (i_cmd.mix2) begin
            r_qprod <= 39'(r_mprod[26:8]) * 39'(odv_pkg::M3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.mix3) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix3) begin
            o_out_data <= {1'b0, bits, (lvl > 18'd16384) ? 15'd16384 : lvl[14:0]};
        end
    end

    assign o_sts.fill_done = i_cmd.fill_red && red_keep
                             && (r_fill_idx == (AW+1)'(NOISE_DEPTH - 1));
    assign o_sts.n_zero    = (w_n == 8'd0);
    assign o_sts.delay_gt1 = (w_delay > 14'd1);
    assign o_sts.need_div  = need_div;
    assign o_sts.vel_zero  = (r_vel == 7'd0);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

endmodule

FILE: sv/one_bit_noise_drum_voices_top.sv
// ----------------------------------------------------------------------------
// one_bit_noise_drum_voices_top
// Eight one-bit noise drum voices with a patch table and a mixed Q1.14 output.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         content
//  s_axis    in         tvalid tready tdata[31:0] tuser  tick / note on / patch
//  m_axis    out        tvalid tready tdata[23:0]        level, voice bits
//  cfg       in         i_cfg_we i_cfg_idx i_cfg_data    four registers
//
//  After reset the noise memory is filled by a sequential generator, each
//  draw a multiply state then a reduce state, with the input held off. A
//  tick walks the eight channels (load, inner steps, final step check,
//  store) after taking the transaction, then mixes; an inner step is a
//  countdown, a clamped reload or a folded reload through the bit-serial
//  remainder unit. Note on runs through its note states, ending early at
//  zero velocity; a patch write is taken in the idle state.
//  A result waits in the output register; the next input is taken meanwhile.
// ----------------------------------------------------------------------------
module one_bit_noise_drum_voices_top #(
    parameter int NOISE_DEPTH = odv_pkg::NOISE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // note[6:0], velocity[13:7], patch_field[16:14], patch_value[30:17]
    input  logic [31:0]               s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // level[14:0], voice_bits[22:15]
    output logic [23:0]               m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [odv_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [odv_pkg::CFG_W-1:0] i_cfg_data
);

    odv_pkg::t_cmd cmd;
    odv_pkg::t_sts sts;

    // sequencer: owns the channel index and divider count
    odv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // datapath: all storage and arithmetic; top bit of tdata is padding
    odv_dp #(
        .NOISE_DEPTH (NOISE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata[30:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the one-bit noise drum voices. Sends ticks, note-ons
// and patch writes with random gaps on both stream sides, mirrors the voices,
// noise memory and mixer in a local behavioural model, and compares every mixed
// sample with the oldest expected one. Runs through several register settings.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] PF_UNUSED6 = 3'd6;
    localparam logic [2:0] PF_UNUSED7 = 3'd7;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         DRAIN_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [odv_pkg::IDX_W-1:0] i_cfg_idx;
    logic [odv_pkg::CFG_W-1:0] i_cfg_data;

    one_bit_noise_drum_voices_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Behavioural copy of the voices
    // ------------------------------------------------------------------
    typedef struct {
        logic [14:0] level;
        logic [7:0]  voice_bits;
    } t_mix;

    t_mix pending_mix[$];

    logic [7:0]  noise_mem [odv_pkg::NOISE_DEPTH];
    logic [7:0]  pat_dur [odv_pkg::PATCHES];
    logic [7:0]  pat_min [odv_pkg::PATCHES];
    logic [7:0]  pat_max [odv_pkg::PATCHES];
    logic [13:0] pat_seed [odv_pkg::PATCHES];
    logic        pat_type [odv_pkg::PATCHES];
    logic [7:0]  pat_vol [odv_pkg::PATCHES];
    logic [15:0] v_dur [odv_pkg::CHANNELS];
    logic [15:0] v_phase [odv_pkg::CHANNELS];
    logic [13:0] v_delay [odv_pkg::CHANNELS];
    logic [13:0] v_ptr [odv_pkg::CHANNELS];
    logic [11:0] v_lo [odv_pkg::CHANNELS];
    logic [11:0] v_hi [odv_pkg::CHANNELS];
    logic [14:0] v_vol [odv_pkg::CHANNELS];
    logic        v_fold [odv_pkg::CHANNELS];
    logic        v_bit [odv_pkg::CHANNELS];

    logic [22:0] r_step;
    logic [7:0]  r_spms;
    logic        r_poly;
    logic [8:0]  r_gain;

    int errors;
    int n_sent;
    int n_mixes;
    int cycles;
    bit quiet;      // stretch with no idling on either side
    int rx_stall;
    int rx_hold;

    function automatic void build_noise();
        longint unsigned x;
        longint unsigned r;
        x = 1;
        for (int i = 0; i < odv_pkg::NOISE_DEPTH; i++) begin
            do begin
                x = (x * 48271) % 64'd2147483647;
                r = x - 1;
            end while (r >= 64'd2147483392);
            noise_mem[i] = 8'(r / 64'd8388607);
        end
    endfunction

    function automatic void voices_reset();
        r_step = odv_pkg::RST_PHASE_STEP;
        r_spms = odv_pkg::RST_SPMS;
        r_poly = odv_pkg::RST_POLY;
        r_gain = odv_pkg::RST_GAIN;
        for (int p = 0; p < odv_pkg::PATCHES; p++) begin
            pat_dur[p] = '0; pat_min[p] = '0; pat_max[p] = '0;
            pat_seed[p] = '0; pat_type[p] = '0; pat_vol[p] = '0;
        end
        for (int c = 0; c < odv_pkg::CHANNELS; c++) begin
            v_dur[c] = '0; v_phase[c] = '0; v_delay[c] = '0; v_ptr[c] = '0;
            v_lo[c] = '0; v_hi[c] = '0; v_vol[c] = '0; v_fold[c] = '0;
            v_bit[c] = '0;
        end
    endfunction

    function automatic void advance_voice(int c);
        int unsigned d;
        if (v_delay[c] > 1) begin
            v_delay[c] = v_delay[c] - 1;
            return;
        end
        d = 8 * noise_mem[v_ptr[c] % odv_pkg::NOISE_DEPTH];
        if (!v_fold[c]) begin
            if (d < v_lo[c]) d = v_lo[c];
            if (d > v_hi[c]) d = v_hi[c];
        end else begin
            if (d < v_lo[c] && v_lo[c] > 0) d = d + v_lo[c];
            if (v_hi[c] > 0) d = d % v_hi[c];
        end
        v_delay[c] = 14'(d);
        v_ptr[c]   = v_ptr[c] + 14'd1;
        v_bit[c]   = ~v_bit[c];
    endfunction

    // returns 1 when the item produces a mixed sample
    function automatic bit voices_apply(logic [1:0] op, logic [6:0] note, logic [6:0] vel,
                                        logic [2:0] fld, logic [13:0] val, output t_mix m);
        int unsigned p, c, a, b, acc, n;
        longint unsigned sum, lvl, g;
        int unsigned chan_of[12] = '{0, 7, 1, 7, 2, 3, 7, 4, 7, 5, 7, 6};
        p = note % 12;
        m.level = '0;
        m.voice_bits = '0;
        if (op == odv_pkg::OP_NOTE) begin
            if (vel == 0) return 0;
            c = r_poly ? chan_of[p] : 0;
            a = pat_min[p];
            b = pat_max[p];
            if (a > b) begin
                n = a; a = b; b = n;
            end
            v_dur[c]   = 16'(int'(pat_dur[p]) * int'(r_spms));
            v_phase[c] = '0;
            v_ptr[c]   = pat_seed[p];
            v_vol[c]   = 15'(int'(pat_vol[p]) * int'(vel) * 64 / 100);
            v_delay[c] = '0;
            v_lo[c]    = 12'(a * 8);
            v_hi[c]    = 12'(b * 8);
            v_fold[c]  = pat_type[p];
            v_bit[c]   = 1'b0;
            return 0;
        end
        if (op == odv_pkg::OP_PATCH) begin
            case (fld)
                odv_pkg::PF_DUR:  pat_dur[p]  = (val > 250) ? 8'd250 : 8'(val);
                odv_pkg::PF_MIN:  pat_min[p]  = (val > 255) ? 8'd255 : 8'(val);
                odv_pkg::PF_MAX:  pat_max[p]  = (val > 255) ? 8'd255 : 8'(val);
                odv_pkg::PF_SEED: pat_seed[p] = val;
                odv_pkg::PF_TYPE: pat_type[p] = (val != 0);
                odv_pkg::PF_VOL:  pat_vol[p]  = (val > 255) ? 8'd255 : 8'(val);
                default: ;
            endcase
            return 0;
        end
        if (op != odv_pkg::OP_TICK) return 0;
        sum = 0;
        for (int ch = 0; ch < odv_pkg::CHANNELS; ch++) begin
            if (v_dur[ch] > 0) begin
                v_dur[ch] = v_dur[ch] - 1;
                acc = v_phase[ch] + r_step;
                n = acc >> 16;
                v_phase[ch] = 16'(acc);
                repeat (n) advance_voice(ch);
            end else begin
                v_bit[ch] = 1'b0;
            end
            if (v_bit[ch]) begin
                sum += v_vol[ch];
                m.voice_bits[ch] = 1'b1;
            end
        end
        g = (r_gain > 256) ? 256 : r_gain;
        lvl = sum * g / 768;
        if (lvl > 16384) lvl = 16384;
        m.level = 15'(lvl);
        return 1;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d (sample %0d)", what, got, want, n_mixes);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold, checking
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_mix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_mixes++;
            if (pending_mix.size() == 0) begin
                report("unexpected sample", int'(m_axis_tdata[14:0]), -1);
            end else begin
                want = pending_mix.pop_front();
                if (m_axis_tdata[14:0] != want.level)
                    report("level", m_axis_tdata[14:0], want.level);
                if (m_axis_tdata[22:15] != want.voice_bits)
                    report("voice_bits", m_axis_tdata[22:15], want.voice_bits);
            end
            // hold the output off long enough to back the block up once
            if (n_mixes == 60) rx_hold <= 400;
            rx_stall <= quiet ? 0 : $urandom_range(0, 6);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one item, wait for its transaction, update the model.
    // Known rows push the typed expectation instead of the modelled one.
    task automatic send(logic [1:0] op, logic [6:0] note, logic [6:0] vel, logic [2:0] fld,
                        logic [13:0] val, bit known = 0, logic [14:0] k_lvl = '0,
                        logic [7:0] k_bits = '0);
        int gap;
        t_mix m;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, val, fld, vel, note};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (voices_apply(op, note, vel, fld, val, m)) begin
            if (known) begin
                m.level = k_lvl;
                m.voice_bits = k_bits;
            end
            pending_mix.push_back(m);
        end
    endtask

    task automatic write_reg(logic [odv_pkg::IDX_W-1:0] idx, logic [odv_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            odv_pkg::CFG_PHASE_STEP: r_step = val;
            odv_pkg::CFG_SPMS:       r_spms = 8'(val);
            odv_pkg::CFG_POLY:       r_poly = val[0];
            default:                 r_gain = 9'(val);
        endcase
    endtask

    // settle the block: last result in, then a pause for any trailing note-on
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_mix.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random traffic: mostly well-formed ticks, note-ons and patch writes,
    // with some noise that the block must ignore (not counted)
    task automatic random_traffic(int count);
        int done;
        int r;
        logic [13:0] v;
        done = 0;
        while (done < count) begin
            if (done % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            v = $urandom_range(0, 1) ? 14'($urandom_range(0, 16383))
                                     : 14'($urandom_range(0, 300));
            if (r < 55) begin
                send(odv_pkg::OP_TICK, 7'($urandom), 7'($urandom), 3'($urandom),
                     14'($urandom));
                done++;
            end else if (r < 70) begin
                send(odv_pkg::OP_NOTE, 7'($urandom), 7'($urandom_range(1, 127)),
                     3'($urandom), v);
                done++;
            end else if (r < 88) begin
                send(odv_pkg::OP_PATCH, 7'($urandom), 7'($urandom),
                     3'($urandom_range(0, 5)), v);
                done++;
            end else if (r < 93) begin
                send(OP_UNUSED, 7'($urandom), 7'($urandom), 3'($urandom), 14'($urandom));
            end else if (r < 97) begin
                send(odv_pkg::OP_PATCH, 7'($urandom), 7'($urandom),
                     $urandom_range(0, 1) ? PF_UNUSED6 : PF_UNUSED7, 14'($urandom));
            end else begin
                send(odv_pkg::OP_NOTE, 7'($urandom), 7'd0, 3'($urandom), 14'($urandom));
            end
        end
        quiet = 0;
    endtask

    typedef struct {
        logic [1:0]  op;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [2:0]  fld;
        logic [13:0] val;
        bit          known;
        logic [14:0] lvl;
        logic [7:0]  bits;
    } t_row;

    t_row directed[$];

    initial begin
        errors = 0; n_sent = 0; n_mixes = 0; cycles = 0;
        quiet = 0; rx_stall = 0; rx_hold = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = odv_pkg::OP_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = odv_pkg::CFG_PHASE_STEP;
        i_cfg_data    = '0;
        build_noise();
        voices_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // silent block after reset, saturating patch writes, ignored codes,
        // zero velocity, folded and clamped voices, sharps onto channel 7
        directed = '{
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    1, 15'd0, 8'd0},
            '{OP_UNUSED,         7'd127, 7'd127, PF_UNUSED7,       14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   odv_pkg::PF_DUR,  14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   odv_pkg::PF_VOL,  14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   odv_pkg::PF_MIN,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   odv_pkg::PF_MAX,  14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd12,  7'd0,   odv_pkg::PF_SEED, 14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   odv_pkg::PF_TYPE, 14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd0,   7'd0,   PF_UNUSED6,       14'd77,   0, 15'd0, 8'd0},
            '{odv_pkg::OP_NOTE,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    1, 15'd0, 8'd0},
            '{odv_pkg::OP_NOTE,  7'd0,   7'd127, odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd1,   7'd0,   odv_pkg::PF_DUR,  14'd5,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd1,   7'd0,   odv_pkg::PF_VOL,  14'd100,  0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd1,   7'd0,   odv_pkg::PF_MIN,  14'd200,  0, 15'd0, 8'd0},
            '{odv_pkg::OP_PATCH, 7'd1,   7'd0,   odv_pkg::PF_MAX,  14'd1,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_NOTE,  7'd1,   7'd1,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_NOTE,  7'd127, 7'd64,  odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd127, 7'd127, odv_pkg::PF_VOL,  14'h3FFF, 0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0},
            '{odv_pkg::OP_TICK,  7'd0,   7'd0,   odv_pkg::PF_DUR,  14'd0,    0, 15'd0, 8'd0}
        };
        foreach (directed[i])
            send(directed[i].op, directed[i].note, directed[i].vel, directed[i].fld,
                 directed[i].val, directed[i].known, directed[i].lvl, directed[i].bits);

        random_traffic(170);
        wait_idle();

        // unit step, shortest notes, one channel only, gain above unity
        write_reg(odv_pkg::CFG_PHASE_STEP, 23'd65536);
        write_reg(odv_pkg::CFG_SPMS, 23'd1);
        write_reg(odv_pkg::CFG_POLY, 23'd0);
        write_reg(odv_pkg::CFG_GAIN, 23'd511);
        random_traffic(180);
        wait_idle();

        // frozen phase, long notes, half gain
        write_reg(odv_pkg::CFG_PHASE_STEP, 23'd0);
        write_reg(odv_pkg::CFG_SPMS, 23'd192);
        write_reg(odv_pkg::CFG_POLY, 23'd1);
        write_reg(odv_pkg::CFG_GAIN, 23'd128);
        random_traffic(130);
        wait_idle();

        // a fast phase step is slow in the block: keep it short, mute output
        write_reg(odv_pkg::CFG_PHASE_STEP, 23'd4194304);
        write_reg(odv_pkg::CFG_GAIN, 23'd0);
        random_traffic(40);
        wait_idle();

        write_reg(odv_pkg::CFG_PHASE_STEP, 23'd200000);
        write_reg(odv_pkg::CFG_SPMS, 23'd100);
        write_reg(odv_pkg::CFG_GAIN, 23'd256);
        random_traffic(170);
        wait_idle();

        $display("covered %0d input transactions and %0d mixed samples over five settings",
                 n_sent, n_mixes);
        $display("errors: %0d, cycles: %0d", errors, cycles);
        if (errors == 0 && pending_mix.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
